// ===== hdl/sriex_pkg.sv =====
// shared types and constants for the small risc instruction executor
package sriex_pkg;
  localparam int unsigned RegCount = 32;
  localparam int unsigned MemWords = 4096;

  localparam logic [4:0] OpAdd   = 5'd0;
  localparam logic [4:0] OpSub   = 5'd1;
  localparam logic [4:0] OpMult  = 5'd2;
  localparam logic [4:0] OpDiv   = 5'd3;
  localparam logic [4:0] OpAnd   = 5'd4;
  localparam logic [4:0] OpOr    = 5'd5;
  localparam logic [4:0] OpXor   = 5'd6;
  localparam logic [4:0] OpShl   = 5'd7;
  localparam logic [4:0] OpShr   = 5'd8;
  localparam logic [4:0] OpSlt   = 5'd9;
  localparam logic [4:0] OpSle   = 5'd10;
  localparam logic [4:0] OpSeq   = 5'd11;
  localparam logic [4:0] OpLoad  = 5'd12;
  localparam logic [4:0] OpStore = 5'd13;
  localparam logic [4:0] OpJmp   = 5'd14;
  localparam logic [4:0] OpBraz  = 5'd15;
  localparam logic [4:0] OpBranz = 5'd16;
  localparam logic [4:0] OpScall = 5'd17;
  localparam logic [4:0] OpStop  = 5'd18;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StHalt    = 3'd1;
  localparam logic [2:0] StBadOp   = 3'd2;
  localparam logic [2:0] StBadSc   = 3'd3;
  localparam logic [2:0] StBadReg  = 3'd4;
  localparam logic [2:0] StBadAddr = 3'd5;
  localparam logic [2:0] StDivZ    = 3'd6;

  localparam logic [1:0] ScPrint  = 2'd0;
  localparam logic [1:0] ScRead   = 2'd1;

  typedef struct packed {
    logic [31:0] instruction;
    logic signed [31:0] host_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic        store_valid;
    logic [11:0] store_address;
    logic signed [31:0] store_value;
    logic        syscall_valid;
    logic [1:0]  syscall_code;
    logic signed [31:0] syscall_value;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load_ins;   // capture instruction beat
    logic rd_ops;     // register file read of operands
    logic mul_go;     // register product
    logic div_go;     // start divider
    logic mem_rd;     // memory read for load
    logic exec;       // commit result
    logic clear_go;   // memory clearing pass
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic is_load;
    logic div_done;
    logic clear_done;
  } stat_t;
endpackage

// ===== hdl/sriex_if.sv =====
// valid/ready channel interfaces for the executor
interface sriex_in_if;
  logic valid;
  logic ready;
  sriex_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sriex_out_if;
  logic valid;
  logic ready;
  sriex_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/small_risc_instruction_executor.sv =====
// top level of the small risc instruction executor
// Input channel in_if carries an instruction word and a host value; the
// output channel out_if carries next pc, status, store and syscall reports.
// After reset a clearing pass zeroes the data memory, one word a cycle,
// before the first beat is accepted. Each instruction takes capture,
// operand read, a stage for multiply, memory read or divider start, then
// commit; a divide holds in commit until the bit-serial divider is done.
// One instruction is in flight at a time; a new beat is taken in the cycle
// after the result beat leaves. The result holds in its register while the
// receiver stalls. Faults and STOP halt the block; later beats report
// halted status.
module small_risc_instruction_executor #(
  parameter int unsigned MEM_WORDS = sriex_pkg::MemWords
) (
  input  logic clk_i,
  input  logic rst_ni,
  sriex_in_if.sink    in_if,
  sriex_out_if.source out_if
);
  sriex_pkg::ctrl_t     ctrl;
  sriex_pkg::stat_t     stat;
  sriex_pkg::out_beat_t res;

  sriex_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  sriex_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .in_i(in_if.data), .stat_o(stat), .res_o(res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl.exec) out_if.data <= res;
  end
endmodule

// ===== hdl/sriex_div.sv =====
// iterative signed divider, one quotient bit a cycle
module sriex_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  // restoring division step
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[31] ? (32'd0 - a_i) : a_i;
      den_d = b_i[31] ? (32'd0 - b_i) : b_i;
      neg_d = a_i[31] ^ b_i[31];
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign q_o = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

// ===== hdl/sriex_datapath.sv =====
// register file, data memory, alu and result formation
module sriex_datapath #(
  parameter int unsigned MEM_WORDS = sriex_pkg::MemWords
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sriex_pkg::ctrl_t      ctrl_i,
  input  sriex_pkg::in_beat_t   in_i,
  output sriex_pkg::stat_t      stat_o,
  output sriex_pkg::out_beat_t  res_o
);
  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0] rf_q [32];
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] ins_q, host_q, pc_q, a_q, b_q, beta_q, prod_q, mrd_q;
  logic        halted_q, badreg_q;
  logic [AW-1:0] clr_q;
  logic        clr_done_q;
  logic [31:0] div_q;
  logic        div_done;

  logic [4:0]  op, alpha, beta;
  logic        immf;
  logic [15:0] opnd;
  logic [31:0] addr;
  logic        addr_ok;

  assign op    = ins_q[31:27];
  assign alpha = ins_q[26:22];
  assign immf  = ins_q[21];
  assign opnd  = ins_q[20:5];
  assign beta  = ins_q[4:0];
  assign addr  = a_q + b_q;
  assign addr_ok = (addr < 32'(MEM_WORDS));

  sriex_div u_div (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_go), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign stat_o.is_mul = (op == sriex_pkg::OpMult) && !halted_q;
  assign stat_o.is_div = (op == sriex_pkg::OpDiv) && !halted_q && !badreg_q && (b_q != 0);
  assign stat_o.is_load = (op == sriex_pkg::OpLoad) && !halted_q;
  assign stat_o.div_done = div_done;
  assign stat_o.clear_done = clr_done_q;

  // instruction capture, operand fetch, product and memory read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_ins) begin
      ins_q <= in_i.instruction;
      host_q <= in_i.host_value;
    end
    if (ctrl_i.rd_ops) begin
      a_q <= rf_q[alpha];
      beta_q <= rf_q[beta];
      b_q <= immf ? {16'd0, opnd} : rf_q[opnd[4:0]];
      badreg_q <= !immf && (opnd[15:5] != '0);
    end
    if (ctrl_i.mul_go) prod_q <= a_q * b_q;
    if (ctrl_i.mem_rd) mrd_q <= mem[addr[AW-1:0]];
  end

  // execute and commit
  logic [31:0] r, target, jt;
  logic [2:0]  st;
  logic        wr, stv, scv;
  logic [4:0]  wi;
  logic [31:0] wv;
  logic        sle;
  always_comb begin
    r = '0; wr = 1'b0; st = sriex_pkg::StOk; stv = 1'b0; scv = 1'b0;
    target = pc_q; wi = beta; jt = {11'd0, ins_q[25:5]};
    sle = ($signed(a_q) < $signed(b_q));
    res_o = '0;
    if (halted_q) st = sriex_pkg::StHalt;
    else if (op <= sriex_pkg::OpStore) begin
      if (badreg_q) st = sriex_pkg::StBadReg;
      else begin
        wr = 1'b1;
        case (op)
          sriex_pkg::OpAdd:  r = a_q + b_q;
          sriex_pkg::OpSub:  r = a_q - b_q;
          sriex_pkg::OpMult: r = prod_q;
          sriex_pkg::OpDiv:  if (b_q == 0) begin st = sriex_pkg::StDivZ; wr = 1'b0; end
                             else r = div_q;
          sriex_pkg::OpAnd:  r = a_q & b_q;
          sriex_pkg::OpOr:   r = a_q | b_q;
          sriex_pkg::OpXor:  r = a_q ^ b_q;
          sriex_pkg::OpShl:  r = a_q << b_q[4:0];
          sriex_pkg::OpShr:  r = 32'($signed(a_q) >>> b_q[4:0]);
          sriex_pkg::OpSlt:  r = {31'd0, sle};
          sriex_pkg::OpSle:  r = {31'd0, sle || (a_q == b_q)};
          sriex_pkg::OpSeq:  r = {31'd0, a_q == b_q};
          sriex_pkg::OpLoad: begin
            if (!addr_ok) begin st = sriex_pkg::StBadAddr; wr = 1'b0; end
            else r = mrd_q;
          end
          default: begin
            wr = 1'b0;
            if (!addr_ok) st = sriex_pkg::StBadAddr;
            else begin
              stv = 1'b1;
              res_o.store_address = addr[11:0];
              res_o.store_value = beta_q;
            end
          end
        endcase
      end
    end else if (op == sriex_pkg::OpJmp) begin
      if (!ins_q[26] && jt[20:5] != '0) st = sriex_pkg::StBadReg;
      else begin
        wr = 1'b1; r = pc_q;
        target = ins_q[26] ? jt : ((jt[4:0] == beta) ? pc_q : rf_q[jt[4:0]]);
      end
    end else if (op == sriex_pkg::OpBraz || op == sriex_pkg::OpBranz) begin
      if ((rf_q[alpha] == 0) == (op == sriex_pkg::OpBraz))
        target = {10'd0, ins_q[21:0]};
    end else if (op == sriex_pkg::OpScall) begin
      if (ins_q[26:0] > 27'd2) st = sriex_pkg::StBadSc;
      else begin
        scv = 1'b1;
        res_o.syscall_code = ins_q[1:0];
        if (ins_q[1:0] == sriex_pkg::ScRead) begin
          wr = 1'b1; wi = 5'd1; r = host_q;
          res_o.syscall_value = host_q;
        end else res_o.syscall_value = rf_q[1];
      end
    end else if (op == sriex_pkg::OpStop) st = sriex_pkg::StHalt;
    else st = sriex_pkg::StBadOp;
    if (st != sriex_pkg::StOk) begin
      target = pc_q; wr = 1'b0; stv = 1'b0; scv = 1'b0;
      res_o.store_address = '0; res_o.store_value = '0;
      res_o.syscall_code = '0; res_o.syscall_value = '0;
    end else if (target == pc_q) target = pc_q + 32'd1;
    wv = r;
    res_o.next_pc = target;
    res_o.status = st;
    res_o.store_valid = stv;
    res_o.syscall_valid = scv;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
      pc_q <= '0; halted_q <= 1'b0; clr_q <= '0; clr_done_q <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        if (wr) rf_q[wi] <= wv;
        if (st != sriex_pkg::StOk) halted_q <= 1'b1;
        else pc_q <= target;
      end
      if (ctrl_i.clear_go) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == AW'(MEM_WORDS - 1)) clr_done_q <= 1'b1;
      end
    end
  end

  // data memory: single write port shared with the clearing pass
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear_go) mem[clr_q] <= '0;
    else if (ctrl_i.exec && stv) mem[addr[AW-1:0]] <= beta_q;
  end
endmodule

// ===== hdl/sriex_ctrl.sv =====
// sequencing state machine
module sriex_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sriex_pkg::stat_t stat_i,
  output sriex_pkg::ctrl_t ctrl_o
);
  typedef enum logic [2:0] {SClear, SIdle, SRead, SWait, SExec, SOut} state_e;
  state_e state_q;
  logic   ov_q;

  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.clear_go = (state_q == SClear);
    ctrl_o.load_ins = (state_q == SIdle) && in_valid_i;
    ctrl_o.rd_ops = (state_q == SRead);
    ctrl_o.mul_go = (state_q == SWait) && stat_i.is_mul;
    ctrl_o.mem_rd = (state_q == SWait) && stat_i.is_load;
    ctrl_o.div_go = (state_q == SWait) && stat_i.is_div;
    ctrl_o.exec = (state_q == SExec) && (!stat_i.is_div || stat_i.div_done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; ov_q <= 1'b0;
    end else begin
      case (state_q)
        SClear: if (stat_i.clear_done) state_q <= SIdle;
        SIdle:  if (in_valid_i) state_q <= SRead;
        SRead:  state_q <= SWait;
        SWait:  state_q <= SExec;
        SExec:  if (ctrl_o.exec) begin state_q <= SOut; ov_q <= 1'b1; end
        SOut:   if (out_ready_i) begin state_q <= SIdle; ov_q <= 1'b0; end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.exec |=> out_valid_o) else $error("commit without result");
  a_no_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.clear_go |-> !in_ready_o) else $error("accept during clear");
endmodule

// ===== tb/tb_small_risc_instruction_executor.sv =====
// self-checking testbench for the small risc instruction executor
module tb_small_risc_instruction_executor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1000;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned LongStall = 400;

  typedef struct {
    logic [31:0] ins;
    logic [31:0] host;
    bit          typed;
    sriex_pkg::out_beat_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sriex_in_if  in_if ();
  sriex_out_if out_if ();

  small_risc_instruction_executor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  // shadow architectural state
  logic [31:0] gpr [sriex_pkg::RegCount];
  logic [31:0] dmem [sriex_pkg::MemWords];
  logic [31:0] pc_q;
  bit          halted_q;

  sriex_pkg::out_beat_t pending_results [$];
  stim_row_t   stim_table [$];
  int unsigned error_count;
  int unsigned result_count;
  int unsigned idle_cycles;
  bit          sender_done;

  // instruction encoders
  function automatic logic [31:0] enc_alu(logic [4:0] op, logic [4:0] alpha, logic immf,
                                          logic [15:0] opnd, logic [4:0] beta);
    return {op, alpha, immf, opnd, beta};
  endfunction

  function automatic logic [31:0] enc_jmp(logic immf, logic [20:0] tgt, logic [4:0] beta);
    return {sriex_pkg::OpJmp, immf, tgt, beta};
  endfunction

  function automatic logic [31:0] enc_br(logic [4:0] op, logic [4:0] alpha, logic [21:0] tgt);
    return {op, alpha, tgt};
  endfunction

  function automatic logic [31:0] enc_sc(logic [26:0] n);
    return {sriex_pkg::OpScall, n};
  endfunction

  function automatic sriex_pkg::out_beat_t ok_beat(logic [31:0] npc);
    sriex_pkg::out_beat_t b;
    b = '0;
    b.next_pc = npc;
    b.status = sriex_pkg::StOk;
    return b;
  endfunction

  // executes one instruction on the shadow state; commit=0 only looks ahead
  function automatic sriex_pkg::out_beat_t exec_instr(logic [31:0] ins, logic [31:0] host,
                                                      bit commit);
    sriex_pkg::out_beat_t o;
    logic [4:0]  op;
    logic [4:0]  alpha;
    logic [4:0]  beta;
    logic [15:0] opnd;
    logic [20:0] jt;
    logic [26:0] n;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] addr;
    logic [31:0] tgt;
    logic [31:0] qmag;
    logic [31:0] jlink;
    logic [2:0]  st;
    bit          reg_wr;
    bit          mem_wr;
    bit          r1_wr;
    op = ins[31:27];
    alpha = ins[26:22];
    opnd = ins[20:5];
    beta = ins[4:0];
    jt = ins[25:5];
    n = ins[26:0];
    o = '0;
    st = sriex_pkg::StOk;
    tgt = pc_q;
    reg_wr = 1'b0;
    mem_wr = 1'b0;
    r1_wr = 1'b0;
    a = '0;
    b = '0;
    r = '0;
    addr = '0;
    if (halted_q) begin
      st = sriex_pkg::StHalt;
    end else if (op <= sriex_pkg::OpStore) begin
      a = gpr[alpha];
      if (ins[21]) b = {16'h0, opnd};
      else if (opnd < sriex_pkg::RegCount) b = gpr[opnd[4:0]];
      else st = sriex_pkg::StBadReg;
      if (st == sriex_pkg::StOk) begin
        reg_wr = 1'b1;
        case (op)
          sriex_pkg::OpAdd:  r = a + b;
          sriex_pkg::OpSub:  r = a - b;
          sriex_pkg::OpMult: r = a * b;
          sriex_pkg::OpDiv: begin
            if (b == 0) begin
              st = sriex_pkg::StDivZ;
              reg_wr = 1'b0;
            end else begin
              qmag = (a[31] ? -a : a) / (b[31] ? -b : b);
              r = (a[31] != b[31]) ? -qmag : qmag;
            end
          end
          sriex_pkg::OpAnd:  r = a & b;
          sriex_pkg::OpOr:   r = a | b;
          sriex_pkg::OpXor:  r = a ^ b;
          sriex_pkg::OpShl:  r = a << b[4:0];
          sriex_pkg::OpShr:  r = $signed(a) >>> b[4:0];
          sriex_pkg::OpSlt:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          sriex_pkg::OpSle:  r = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
          sriex_pkg::OpSeq:  r = (a == b) ? 32'd1 : 32'd0;
          default: begin
            reg_wr = 1'b0;
            addr = a + b;
            if (addr >= sriex_pkg::MemWords) begin
              st = sriex_pkg::StBadAddr;
            end else if (op == sriex_pkg::OpLoad) begin
              reg_wr = 1'b1;
              r = dmem[addr[11:0]];
            end else begin
              mem_wr = 1'b1;
              o.store_valid = 1'b1;
              o.store_address = addr[11:0];
              o.store_value = gpr[beta];
            end
          end
        endcase
      end
    end else if (op == sriex_pkg::OpJmp) begin
      if (!ins[26] && jt >= sriex_pkg::RegCount) begin
        st = sriex_pkg::StBadReg;
      end else begin
        reg_wr = 1'b1;
        r = pc_q;
        // link is written before a register target is read
        jlink = (jt[4:0] == beta) ? pc_q : gpr[jt[4:0]];
        tgt = ins[26] ? {11'h0, jt} : jlink;
      end
    end else if (op == sriex_pkg::OpBraz || op == sriex_pkg::OpBranz) begin
      if ((gpr[alpha] == 0) == (op == sriex_pkg::OpBraz)) tgt = {10'h0, ins[21:0]};
    end else if (op == sriex_pkg::OpScall) begin
      if (n > 2) begin
        st = sriex_pkg::StBadSc;
      end else begin
        r1_wr = (n == sriex_pkg::ScRead);
        o.syscall_valid = 1'b1;
        o.syscall_code = n[1:0];
        o.syscall_value = r1_wr ? host : gpr[1];
      end
    end else if (op == sriex_pkg::OpStop) begin
      st = sriex_pkg::StHalt;
    end else begin
      st = sriex_pkg::StBadOp;
    end
    if (st != sriex_pkg::StOk) begin
      o = '0;
      tgt = pc_q;
    end else if (tgt == pc_q) begin
      tgt = pc_q + 32'd1;
    end
    o.next_pc = tgt;
    o.status = st;
    if (commit) begin
      if (st != sriex_pkg::StOk) begin
        halted_q = 1'b1;
      end else begin
        if (reg_wr) gpr[beta] = r;
        if (mem_wr) dmem[addr[11:0]] = gpr[beta];
        if (r1_wr) gpr[1] = host;
        pc_q = tgt;
      end
    end
    return o;
  endfunction

  // random instruction that keeps the block running
  function automatic logic [31:0] rand_instr();
    logic [31:0] ins;
    logic [4:0]  op;
    logic [4:0]  alpha;
    sriex_pkg::out_beat_t peek;
    int          w;
    repeat (60) begin
      w = $urandom_range(0, 99);
      alpha = 5'($urandom_range(0, 31));
      if (w < 45) op = 5'($urandom_range(0, 11));
      else if (w < 70) op = $urandom_range(0, 1) ? sriex_pkg::OpLoad : sriex_pkg::OpStore;
      else if (w < 80) op = sriex_pkg::OpJmp;
      else if (w < 92) op = $urandom_range(0, 1) ? sriex_pkg::OpBraz : sriex_pkg::OpBranz;
      else op = sriex_pkg::OpScall;
      case (op)
        sriex_pkg::OpJmp: begin
          if ($urandom_range(0, 1)) ins = enc_jmp(1'b1, 21'($urandom), 5'($urandom));
          else ins = enc_jmp(1'b0, 21'($urandom_range(0, 31)), 5'($urandom));
        end
        sriex_pkg::OpBraz, sriex_pkg::OpBranz: ins = enc_br(op, alpha, 22'($urandom));
        sriex_pkg::OpScall: ins = enc_sc(27'($urandom_range(0, 2)));
        sriex_pkg::OpLoad, sriex_pkg::OpStore:
          ins = enc_alu(op, alpha, 1'b1, 16'($urandom_range(0, 4095)), 5'($urandom));
        default: begin
          if ($urandom_range(0, 1)) ins = enc_alu(op, alpha, 1'b1, 16'($urandom), 5'($urandom));
          else ins = enc_alu(op, alpha, 1'b0, 16'($urandom_range(0, 31)), 5'($urandom));
          // sometimes keep a register small so memory addresses stay in range
          if ($urandom_range(0, 3) == 0)
            ins = enc_alu(sriex_pkg::OpAnd, alpha, 1'b1, 16'h07FF, 5'($urandom));
        end
      endcase
      peek = exec_instr(ins, 32'd0, 1'b0);
      if (peek.status == sriex_pkg::StOk) return ins;
    end
    return enc_alu(sriex_pkg::OpAdd, 5'd0, 1'b1, 16'($urandom), 5'($urandom));
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 60) return 0;
    if (w < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // drive one beat and record what it should produce
  task automatic send_beat(logic [31:0] ins, logic [31:0] host, bit typed,
                           sriex_pkg::out_beat_t res, bit calm);
    sriex_pkg::out_beat_t predicted;
    int unsigned gap;
    gap = calm ? 0 : rand_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      in_if.data <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {ins, host};
    predicted = exec_instr(ins, host, 1'b1);
    pending_results.push_back(typed ? res : predicted);
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %h actual %h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // directed rows: extremes, every operation but STOP, the named corner cases
  task automatic build_table();
    stim_row_t row;
    logic [31:0] d [$];
    d.push_back(enc_alu(sriex_pkg::OpSub, 5'd0, 1'b1, 16'h0001, 5'd4));   // r4 = -1
    d.push_back(enc_alu(sriex_pkg::OpAdd, 5'd0, 1'b1, 16'h0001, 5'd9));
    d.push_back(enc_alu(sriex_pkg::OpShl, 5'd9, 1'b1, 16'h001F, 5'd8));   // r8 = most negative
    d.push_back(enc_alu(sriex_pkg::OpMult, 5'd3, 1'b0, 16'd3, 5'd6));
    d.push_back(enc_alu(sriex_pkg::OpDiv, 5'd8, 1'b0, 16'd4, 5'd10));     // most negative / -1
    d.push_back(enc_alu(sriex_pkg::OpDiv, 5'd4, 1'b1, 16'h0002, 5'd11));  // truncates to zero
    d.push_back(enc_alu(sriex_pkg::OpAnd, 5'd3, 1'b0, 16'd4, 5'd12));
    d.push_back(enc_alu(sriex_pkg::OpOr, 5'd8, 1'b0, 16'd3, 5'd13));
    d.push_back(enc_alu(sriex_pkg::OpXor, 5'd4, 1'b0, 16'd31, 5'd14));
    d.push_back(enc_alu(sriex_pkg::OpShr, 5'd8, 1'b1, 16'h0021, 5'd15)); // low 5 bits count
    d.push_back(enc_alu(sriex_pkg::OpShr, 5'd8, 1'b1, 16'h0000, 5'd16));
    d.push_back(enc_alu(sriex_pkg::OpSlt, 5'd8, 1'b0, 16'd4, 5'd17));
    d.push_back(enc_alu(sriex_pkg::OpSlt, 5'd4, 1'b0, 16'd8, 5'd18));
    d.push_back(enc_alu(sriex_pkg::OpSle, 5'd4, 1'b0, 16'd4, 5'd19));
    d.push_back(enc_alu(sriex_pkg::OpSeq, 5'd3, 1'b1, 16'hFFFF, 5'd20));
    d.push_back(enc_alu(sriex_pkg::OpSeq, 5'd3, 1'b1, 16'h0000, 5'd21));
    d.push_back(enc_alu(sriex_pkg::OpStore, 5'd0, 1'b1, 16'd4095, 5'd3));
    d.push_back(enc_alu(sriex_pkg::OpLoad, 5'd0, 1'b1, 16'd4095, 5'd22));
    d.push_back(enc_alu(sriex_pkg::OpStore, 5'd0, 1'b1, 16'd0, 5'd8));
    d.push_back(enc_jmp(1'b0, 21'd23, 5'd23));                 // link equals target register
    d.push_back(enc_jmp(1'b1, 21'h1FFFFF, 5'd24));
    d.push_back(enc_br(sriex_pkg::OpBranz, 5'd0, 22'h3FFFFF));
    d.push_back(enc_br(sriex_pkg::OpBraz, 5'd0, 22'h3FFFFF));
    d.push_back(enc_sc(27'd1));
    d.push_back(enc_sc(27'd0));
    d.push_back(enc_sc(27'd2));
    // first two rows follow straight from reset
    row.ins = enc_alu(sriex_pkg::OpAdd, 5'd0, 1'b1, 16'hFFFF, 5'd3);
    row.host = 32'd0;
    row.typed = 1'b1;
    row.res = ok_beat(32'd1);
    stim_table.push_back(row);
    row.ins = enc_alu(sriex_pkg::OpSub, 5'd0, 1'b1, 16'h0001, 5'd5);
    row.res = ok_beat(32'd2);
    stim_table.push_back(row);
    foreach (d[i]) begin
      row.ins = d[i];
      row.host = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      row.typed = 1'b0;
      stim_table.push_back(row);
    end
  endtask

  // one fault ends the run's useful work, so it comes last
  function automatic logic [31:0] fault_instr();
    case ($urandom_range(0, 6))
      0: return enc_alu(5'($urandom_range(0, 13)), 5'($urandom), 1'b0,
                        16'($urandom_range(32, 65535)), 5'($urandom));
      1: return enc_alu(sriex_pkg::OpDiv, 5'd0, 1'b1, 16'h0000, 5'($urandom));
      2: return enc_alu(sriex_pkg::OpLoad, 5'd0, 1'b1, 16'($urandom_range(4096, 65535)),
                        5'($urandom));
      3: return {5'($urandom_range(19, 31)), 27'($urandom)};
      4: return enc_sc(27'($urandom_range(3, 32'h07FF_FFFF)));
      5: return enc_jmp(1'b0, 21'($urandom_range(32, 32'h001F_FFFF)), 5'($urandom));
      default: return {sriex_pkg::OpStop, 27'($urandom)};
    endcase
  endfunction

  // stimulus
  initial begin
    bit calm;
    in_if.valid = 1'b0;
    in_if.data = '0;
    sender_done = 1'b0;
    halted_q = 1'b0;
    pc_q = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    build_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (stim_table[i])
      send_beat(stim_table[i].ins, stim_table[i].host, stim_table[i].typed,
                stim_table[i].res, 1'b0);
    for (int i = 0; i < NumRandom; i++) begin
      calm = ((i / 100) % 4 == 3);
      if (i == NumRandom / 2) begin
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      send_beat(rand_instr(), $urandom, 1'b0, '0, calm);
    end
    send_beat(fault_instr(), $urandom, 1'b0, '0, 1'b0);
    repeat (5) send_beat($urandom, $urandom, 1'b0, '0, 1'b0);
    in_if.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // result side: random back-pressure and one long hold-off
  initial begin
    sriex_pkg::out_beat_t want;
    sriex_pkg::out_beat_t got;
    bit          stalled_once;
    int unsigned hold;
    out_if.ready = 1'b0;
    error_count = 0;
    result_count = 0;
    stalled_once = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, got);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
          check_field("store_address", 32'(want.store_address), 32'(got.store_address));
          check_field("store_value", want.store_value, got.store_value);
          check_field("syscall_valid", 32'(want.syscall_valid), 32'(got.syscall_valid));
          check_field("syscall_code", 32'(want.syscall_code), 32'(got.syscall_code));
          check_field("syscall_value", want.syscall_value, got.syscall_value);
        end
      end
      if (!stalled_once && result_count == 300) begin
        stalled_once = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if ((result_count / 150) % 3 == 2) begin
        out_if.ready <= 1'b1;
      end else begin
        hold = rand_gap();
        out_if.ready <= (hold == 0);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (sender_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
